[design/coap_pkg.sv]
// Shared types, codes and helper functions for the CoAP option parser.
// No dependencies; imported by coap_step and coap_option_parser.
`default_nettype none
package coap_pkg;

  // Parse phases
  localparam logic [2:0] PH_TOKEN     = 3'd0;
  localparam logic [2:0] PH_HEADER    = 3'd1;
  localparam logic [2:0] PH_DELTA_EXT = 3'd2;
  localparam logic [2:0] PH_LEN_EXT   = 3'd3;
  localparam logic [2:0] PH_VALUE     = 3'd4;
  localparam logic [2:0] PH_PAYLOAD   = 3'd5;
  localparam logic [2:0] PH_ERROR     = 3'd6;
  localparam logic [2:0] PH_DONE      = 3'd7;

  // Byte kinds
  localparam logic [2:0] KIND_TOKEN   = 3'd0;
  localparam logic [2:0] KIND_HEADER  = 3'd1;
  localparam logic [2:0] KIND_VALUE   = 3'd2;
  localparam logic [2:0] KIND_MARKER  = 3'd3;
  localparam logic [2:0] KIND_PAYLOAD = 3'd4;
  localparam logic [2:0] KIND_IGNORED = 3'd5;

  // Status codes
  localparam logic [2:0] ST_BUSY       = 3'd0;
  localparam logic [2:0] ST_OK_PAYLOAD = 3'd1;
  localparam logic [2:0] ST_OK_EMPTY   = 3'd2;
  localparam logic [2:0] ST_TRUNCATED  = 3'd3;
  localparam logic [2:0] ST_BAD_NIBBLE = 3'd4;
  localparam logic [2:0] ST_UNKNOWN    = 3'd5;
  localparam logic [2:0] ST_URI_LONG   = 3'd6;

  // URI targets
  localparam logic [1:0] TGT_NONE  = 2'd0;
  localparam logic [1:0] TGT_PATH  = 2'd1;
  localparam logic [1:0] TGT_QUERY = 2'd2;

  // Option numbers with special handling
  localparam logic [15:0] OPT_URI_PATH  = 16'd11;
  localparam logic [15:0] OPT_URI_QUERY = 16'd15;
  localparam logic [15:0] OPT_BLOCK2    = 16'd23;
  localparam logic [15:0] OPT_BLOCK1    = 16'd27;

  localparam logic [7:0] PAYLOAD_MARKER = 8'hFF;
  localparam logic [3:0] NIB_EXT8       = 4'd13;
  localparam logic [3:0] NIB_EXT16      = 4'd14;
  localparam logic [3:0] NIB_BAD        = 4'd15;
  localparam logic [16:0] EXT8_BIAS     = 17'd13;
  localparam logic [16:0] EXT16_BIAS    = 17'd269;

  typedef struct packed {
    logic [2:0]  phase;
    logic [3:0]  token_left;
    logic [15:0] cur_opt;
    logic [15:0] ext_val;
    logic [1:0]  ext_left;
    logic        ext_wide;
    logic [3:0]  pend_len;
    logic [16:0] value_left;
    logic        value_started;
    logic [7:0]  path_used;
    logic [7:0]  query_used;
    logic        query_sep;
    logic [2:0]  pend_err;
    logic [7:0]  block_byte;
    logic [2:0]  error_code;
    logic [15:0] payload_count;
    logic        confirmable;
  } state_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] opt;
    logic [1:0]  tgt;
    logic        sep;
    logic [2:0]  status;
    logic        ack;
    logic [7:0]  block;
    logic [15:0] plen;
  } res_t;

  function automatic logic opt_known(input logic [15:0] n);
    logic k;
    unique case (n)
      16'd1, 16'd3, 16'd4, 16'd5, 16'd7, 16'd8, 16'd11, 16'd12,
      16'd14, 16'd15, 16'd17, 16'd20, 16'd23, 16'd27, 16'd35, 16'd39,
      16'd60:  k = 1'b1;
      default: k = 1'b0;
    endcase
    return k;
  endfunction

  // Saturating add of an option delta
  function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [16:0] d);
    logic [17:0] s;
    s = {2'b00, a} + {1'b0, d};
    return (s > 18'd65535) ? 16'hFFFF : s[15:0];
  endfunction

endpackage
`default_nettype wire

[design/coap_step.sv]
// Next-state and result logic for one message byte of the CoAP option parser.
// Purely combinational; uses coap_pkg.
`default_nettype none
module coap_step #(
  parameter int MAX_TOKEN_BYTES = 8
) (
  input  coap_pkg::state_t st_i,
  input  logic [7:0]       data_byte,
  input  logic             first_byte,
  input  logic             last_byte,
  input  logic [3:0]       token_length,
  input  logic             is_confirmable,
  input  logic [7:0]       uri_limit,
  output coap_pkg::state_t st_o,
  output coap_pkg::res_t   res_o
);
  import coap_pkg::*;

  localparam logic [3:0] TOK_MAX = 4'(MAX_TOKEN_BYTES);

  state_t      s;
  logic [2:0]  kind;
  logic [1:0]  tgt;
  logic        sep;
  logic [2:0]  status;
  logic        ack;
  logic        do_hdr;
  logic        do_start;
  logic        do_finish;
  logic [16:0] fin_len;
  logic [16:0] ext_sum;
  logic [17:0] uri_sum;
  logic [1:0]  left_dec;

  always_comb begin
    s         = st_i;
    kind      = KIND_IGNORED;
    tgt       = TGT_NONE;
    sep       = 1'b0;
    status    = ST_BUSY;
    ack       = 1'b0;
    do_hdr    = 1'b0;
    do_start  = 1'b0;
    do_finish = 1'b0;
    fin_len   = '0;
    ext_sum   = '0;
    uri_sum   = '0;
    left_dec  = '0;

    if (first_byte) begin
      s               = '0;
      s.phase         = PH_TOKEN;
      s.token_left    = (token_length > TOK_MAX) ? TOK_MAX : token_length;
      s.confirmable   = is_confirmable;
    end

    unique case (s.phase)
      PH_TOKEN: begin
        if (s.token_left != 4'd0) begin
          kind         = KIND_TOKEN;
          s.token_left = s.token_left - 4'd1;
          if (s.token_left == 4'd0) s.phase = PH_HEADER;
        end else begin
          do_hdr = 1'b1;
        end
      end
      PH_HEADER: do_hdr = 1'b1;
      PH_DELTA_EXT, PH_LEN_EXT: begin
        kind      = KIND_HEADER;
        s.ext_val = {s.ext_val[7:0], data_byte};
        left_dec  = (s.ext_left != 2'd0) ? s.ext_left - 2'd1 : 2'd0;
        s.ext_left = left_dec;
        if (left_dec == 2'd0) begin
          ext_sum = {1'b0, s.ext_val} + (s.ext_wide ? EXT16_BIAS : EXT8_BIAS);
          if (s.phase == PH_DELTA_EXT) begin
            s.cur_opt = sat_add(s.cur_opt, ext_sum);
            do_start  = 1'b1;
          end else begin
            do_finish = 1'b1;
            fin_len   = ext_sum;
          end
        end
      end
      PH_VALUE: begin
        kind = KIND_VALUE;
        if (s.pend_err == 3'd0 && s.cur_opt == OPT_URI_PATH)  tgt = TGT_PATH;
        if (s.pend_err == 3'd0 && s.cur_opt == OPT_URI_QUERY) tgt = TGT_QUERY;
        if (!s.value_started) begin
          if (tgt == TGT_PATH)  sep = 1'b1;
          if (tgt == TGT_QUERY) sep = s.query_sep;
          if (s.cur_opt == OPT_BLOCK2 || s.cur_opt == OPT_BLOCK1) s.block_byte = data_byte;
        end
        s.value_started = 1'b1;
        if (s.value_left != 17'd0) s.value_left = s.value_left - 17'd1;
        if (s.value_left == 17'd0) begin
          if (s.pend_err != 3'd0) begin
            s.error_code = s.pend_err;
            s.phase      = PH_ERROR;
          end else begin
            s.phase = PH_HEADER;
          end
        end
      end
      PH_PAYLOAD: begin
        kind = KIND_PAYLOAD;
        if (s.payload_count != 16'hFFFF) s.payload_count = s.payload_count + 16'd1;
      end
      default: ;
    endcase

    // Option header byte
    if (do_hdr) begin
      kind = KIND_HEADER;
      if (data_byte == PAYLOAD_MARKER) begin
        kind    = KIND_MARKER;
        s.phase = PH_PAYLOAD;
      end else begin
        s.pend_len = data_byte[3:0];
        if (data_byte[7:4] == NIB_BAD) begin
          s.error_code = ST_BAD_NIBBLE;
          s.phase      = PH_ERROR;
        end else if (data_byte[7:4] == NIB_EXT8 || data_byte[7:4] == NIB_EXT16) begin
          s.ext_wide = (data_byte[7:4] == NIB_EXT16);
          s.ext_left = (data_byte[7:4] == NIB_EXT16) ? 2'd2 : 2'd1;
          s.ext_val  = '0;
          s.phase    = PH_DELTA_EXT;
        end else begin
          s.cur_opt = sat_add(s.cur_opt, {13'd0, data_byte[7:4]});
          do_start  = 1'b1;
        end
      end
    end

    // Length nibble
    if (do_start) begin
      if (s.pend_len == NIB_BAD) begin
        s.error_code = ST_BAD_NIBBLE;
        s.phase      = PH_ERROR;
      end else if (s.pend_len == NIB_EXT8 || s.pend_len == NIB_EXT16) begin
        s.ext_wide = (s.pend_len == NIB_EXT16);
        s.ext_left = (s.pend_len == NIB_EXT16) ? 2'd2 : 2'd1;
        s.ext_val  = '0;
        s.phase    = PH_LEN_EXT;
      end else begin
        do_finish = 1'b1;
        fin_len   = {13'd0, s.pend_len};
      end
    end

    // Option length known: check the option and the URI budget
    if (do_finish) begin
      s.pend_err  = 3'd0;
      s.query_sep = 1'b0;
      if (!opt_known(s.cur_opt)) begin
        s.pend_err = ST_UNKNOWN;
      end else if (s.cur_opt == OPT_URI_PATH) begin
        uri_sum = {10'd0, s.path_used} + {1'b0, fin_len} + 18'd1;
        if (uri_sum < {10'd0, uri_limit}) s.path_used = uri_sum[7:0];
        else s.pend_err = ST_URI_LONG;
      end else if (s.cur_opt == OPT_URI_QUERY) begin
        uri_sum = {10'd0, s.query_used} + {1'b0, fin_len} + 18'd1;
        if (uri_sum < {10'd0, uri_limit}) begin
          s.query_sep  = (s.query_used != 8'd0);
          s.query_used = s.query_used + fin_len[7:0] + {7'd0, s.query_sep};
        end else begin
          s.pend_err = ST_URI_LONG;
        end
      end else if ((s.cur_opt == OPT_BLOCK2 || s.cur_opt == OPT_BLOCK1) &&
                   fin_len == 17'd0) begin
        s.block_byte = 8'd0;
      end
      s.value_left    = fin_len;
      s.value_started = 1'b0;
      if (fin_len == 17'd0) begin
        if (s.pend_err == 3'd0 && s.cur_opt == OPT_URI_PATH) begin
          tgt = TGT_PATH;
          sep = 1'b1;
        end
        if (s.pend_err == 3'd0 && s.cur_opt == OPT_URI_QUERY) begin
          tgt = TGT_QUERY;
          sep = s.query_sep;
        end
        if (s.pend_err != 3'd0) begin
          s.error_code = s.pend_err;
          s.phase      = PH_ERROR;
        end else begin
          s.phase = PH_HEADER;
        end
      end else begin
        s.phase = PH_VALUE;
      end
    end

    // End of message
    if (last_byte && s.phase != PH_DONE) begin
      priority if (s.phase == PH_PAYLOAD) begin
        status = ST_OK_PAYLOAD;
      end else if (s.phase == PH_HEADER) begin
        status = ST_OK_EMPTY;
      end else begin
        if (s.phase != PH_ERROR) s.error_code = ST_TRUNCATED;
        status = s.error_code;
        ack    = s.confirmable;
      end
      s.phase = PH_DONE;
    end
  end

  assign st_o         = s;
  assign res_o.kind   = kind;
  assign res_o.opt    = s.cur_opt;
  assign res_o.tgt    = tgt;
  assign res_o.sep    = sep;
  assign res_o.status = status;
  assign res_o.ack    = ack;
  assign res_o.block  = s.block_byte;
  assign res_o.plen   = s.payload_count;

endmodule
`default_nettype wire

[design/coap_option_parser.sv]
// Top level of the CoAP option parser: stream ports, state and result registers.
// Depends on coap_pkg and coap_step.
`default_nettype none
// The parser takes the bytes that follow the 4-byte CoAP header, one beat per
// byte, token first, and returns one result beat for every byte. It skips the
// token, decodes option headers with their 13/269 extensions, accumulates the
// option number (saturating at 65535), tags URI path and query value bytes with
// their '/' and '&' separators, checks both against uri_limit and keeps the
// first value byte of the latest Block1/Block2 option. The status, the ACK flag
// and the final payload length are meaningful on the result of the byte marked
// last; status reads 0 on every other byte. Only the RFC 7252 options and
// Block1/Block2 are accepted. Throughput is one byte per clock: the whole parse
// step sits between the state registers and the result register, so a result
// appears in the cycle after its byte is taken, and a new byte is taken while a
// result waits as long as the consumer takes that result in the same cycle. Write
// uri_limit only while no byte is in flight; it resets to MAX_URI_BYTES.
module coap_option_parser #(
  parameter int MAX_URI_BYTES   = 128,
  parameter int MAX_TOKEN_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input bytes
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] data_byte, [11:8] token_length,
                                  // [12] is_confirmable, [15:13] zero
  input  logic        in_tlast,   // last_byte
  input  logic        in_tuser,   // first_byte
  // Results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [15:0] option_number, [17:16] uri_target,
                                  // [18] separator_first, [21:19] status,
                                  // [22] reply_with_ack, [30:23] block_size_byte,
                                  // [46:31] payload_bytes, [47] zero
  output logic [2:0]  out_tuser,  // byte_kind
  // uri_limit register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);
  import coap_pkg::*;

  state_t     st_r;
  state_t     st_nxt;
  res_t       res_nxt;
  res_t       res_r;
  logic       out_valid_r;
  logic [7:0] uri_limit_r;
  logic       in_fire;

  // Take a byte whenever the result register is empty or drains this cycle
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  coap_step #(
    .MAX_TOKEN_BYTES(MAX_TOKEN_BYTES)
  ) u_step (
    .st_i           (st_r),
    .data_byte      (in_tdata[7:0]),
    .first_byte     (in_tuser),
    .last_byte      (in_tlast),
    .token_length   (in_tdata[11:8]),
    .is_confirmable (in_tdata[12]),
    .uri_limit      (uri_limit_r),
    .st_o           (st_nxt),
    .res_o          (res_nxt)
  );

  // Parser state: advance on every accepted byte; all zero is the token phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (in_fire) begin
      st_r <= st_nxt;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      uri_limit_r <= 8'(MAX_URI_BYTES);
    end else if (cfg_valid && cfg_ready) begin
      uri_limit_r <= cfg_data;
    end
  end

  // Result register: load on accept, hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.kind;
  assign out_tdata  = {1'b0, res_r.plen, res_r.block, res_r.ack, res_r.status,
                       res_r.sep, res_r.tgt, res_r.opt};

  // An accepted byte always leaves a result behind
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_tvalid)
    else $error("accepted byte produced no result");

  // The last byte closes the message
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tlast) |=> (st_r.phase == PH_DONE))
    else $error("last byte did not close the message");

  // The token counter never starts above the token limit
  a_token_cut: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tuser) |=> (st_r.token_left <= 4'(MAX_TOKEN_BYTES)))
    else $error("token count above limit");

  // An ACK is only requested together with an error status
  a_ack_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && res_r.ack) |->
      (res_r.status == ST_TRUNCATED || res_r.status == ST_BAD_NIBBLE ||
       res_r.status == ST_UNKNOWN || res_r.status == ST_URI_LONG))
    else $error("ACK without error status");

  // URI text is only tagged on value bytes or option headers
  a_uri_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && res_r.tgt != TGT_NONE) |->
      (res_r.kind == KIND_VALUE || res_r.kind == KIND_HEADER))
    else $error("URI target on a byte that carries no URI text");

endmodule
`default_nettype wire
